// ----- hdl/tolt_pkg.sv -----
// Shared types and constants of the timed owner lookup table.
package tolt_pkg;

   localparam int ID_W    = 31;
   localparam int TIME_W  = 64;
   localparam int UID_W   = 32;

   // command codes
   localparam logic CMD_APPEND = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   // one stored event
   typedef struct packed {
      logic [UID_W-1:0]  uid;
      logic              owner_known;
      logic [ID_W-1:0]   parent;
      logic              parent_known;
      logic              is_open;
      logic [TIME_W-1:0] stamp;
      logic [ID_W-1:0]   pid;
   } entry_type;

   // running best match that travels down the chain
   typedef struct packed {
      logic              hit;
      logic [TIME_W-1:0] stamp;
      logic              is_open;
      logic              parent_known;
      logic [ID_W-1:0]   parent;
      logic              owner_known;
      logic [UID_W-1:0]  uid;
   } best_type;

endpackage

// ----- hdl/tolt_cell.sv -----
// One cell of the entry chain: holds one event and folds it into the best match.
module tolt_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  tolt_pkg::entry_type   wr_entry,
   input  logic [tolt_pkg::ID_W-1:0]   key_id,
   input  logic [tolt_pkg::TIME_W-1:0] key_time,
   input  logic                  scan_en,
   input  tolt_pkg::best_type    best_i,
   output tolt_pkg::best_type    best_o
);
   import tolt_pkg::*;

   entry_type entry_ff;
   logic      full_ff;
   best_type  best_ff, best_in;
   logic      take;

   // store the event once
   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else if (wr_en) begin
         full_ff <= 1'b1;
      end
      if (wr_en) begin
         entry_ff <= wr_entry;
      end
   end

   // take this entry on strictly later stamp; earlier entries win ties
   always_comb begin
      take = full_ff && entry_ff.pid == key_id && entry_ff.stamp <= key_time &&
             (!best_i.hit || entry_ff.stamp > best_i.stamp);
      best_in = best_i;
      if (take) begin
         best_in.hit          = 1'b1;
         best_in.stamp        = entry_ff.stamp;
         best_in.is_open      = entry_ff.is_open;
         best_in.parent_known = entry_ff.parent_known;
         best_in.parent       = entry_ff.parent;
         best_in.owner_known  = entry_ff.owner_known;
         best_in.uid          = entry_ff.uid;
      end
   end

   // hand the match to the next cell
   always_ff @(posedge clock) begin
      if (scan_en) begin
         best_ff <= best_in;
      end
   end

   assign best_o = best_ff;
endmodule

// ----- hdl/timed_owner_lookup_table_unit.sv -----
// Top level of the timed owner lookup table.
// Usage: req_ carries one command per transfer: append an event or search
// the owner uid of an id at a time. rsp_ returns one result per command.
// An append is answered from ST_DONE via the output register; the event lands in the
// cell at the fill position, or table_full is set when all cells are used.
// A search sends the query through the row of TABLE_DEPTH cells, one cell a
// cycle, and repeats for each parent hop, at most MAX_HOPS passes in all.
// One command is worked on at a time.
// Reset empties the table (the fill count goes to zero) and drops any
// command in flight. A result waits in the output register while rsp_tready
// is low; req_tready stays low until that result is taken.
module timed_owner_lookup_table_unit #(
   parameter int TABLE_DEPTH = 256,
   parameter int MAX_HOPS    = 10
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: proc_id[30:0], stamp[94:31], is_open[95], parent_id[126:96],
   // parent_known[127], owner_uid[159:128], owner_known[160], zeros to 167
   input  logic [167:0] req_tdata,
   // tuser: cmd
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: result_id[30:0], result_uid[62:31], uid_found[63], table_full[64],
   // zeros to 71
   output logic [71:0]  rsp_tdata
);
   import tolt_pkg::*;

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int HOP_W = $clog2(MAX_HOPS + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  step_ff, step_in;
   logic [HOP_W-1:0]  hop_ff, hop_in;
   logic [ID_W-1:0]   qid_ff, qid_in, cur_ff, cur_in;
   logic [TIME_W-1:0] qtime_ff, qtime_in;
   logic              out_v_ff, out_v_in;
   logic [UID_W-1:0]  uid_ff, uid_in;
   logic              found_ff, found_in, full_ff, full_in;

   entry_type         wr_entry;
   logic              accept, do_append, scan_en;
   best_type          chain [TABLE_DEPTH+1];
   best_type          res;

   assign accept    = req_tvalid && req_tready;
   assign do_append = accept && req_tuser == CMD_APPEND && count_ff < CNT_W'(TABLE_DEPTH);
   assign scan_en   = state_ff == ST_SCAN;

   assign wr_entry.pid          = req_tdata[30:0];
   assign wr_entry.stamp        = req_tdata[94:31];
   assign wr_entry.is_open      = req_tdata[95];
   assign wr_entry.parent       = req_tdata[126:96];
   assign wr_entry.parent_known = req_tdata[127];
   assign wr_entry.uid          = req_tdata[159:128];
   assign wr_entry.owner_known  = req_tdata[160];

   // empty match enters the head of the chain
   assign chain[0] = '0;

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      tolt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .wr_en    (do_append && count_ff[IDX_W-1:0] == IDX_W'(g)),
         .wr_entry (wr_entry),
         .key_id   (cur_ff),
         .key_time (qtime_ff),
         .scan_en  (scan_en),
         .best_i   (chain[g]),
         .best_o   (chain[g+1])
      );
   end

   assign res = chain[TABLE_DEPTH];

   // sequence commands and parent hops
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      step_in  = step_ff;
      hop_in   = hop_ff;
      qid_in   = qid_ff;
      cur_in   = cur_ff;
      qtime_in = qtime_ff;
      out_v_in = out_v_ff;
      uid_in   = uid_ff;
      found_in = found_ff;
      full_in  = full_ff;
      if (rsp_tvalid && rsp_tready) begin
         out_v_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               qid_in   = req_tdata[30:0];
               cur_in   = req_tdata[30:0];
               qtime_in = req_tdata[94:31];
               uid_in   = '0;
               found_in = 1'b0;
               full_in  = 1'b0;
               if (req_tuser == CMD_APPEND) begin
                  if (do_append) begin
                     count_in = count_ff + 1'b1;
                  end else begin
                     full_in = 1'b1;
                  end
                  state_in = ST_DONE;
               end else begin
                  step_in  = '0;
                  hop_in   = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (step_ff == CNT_W'(TABLE_DEPTH)) begin
               // match has left the last cell
               state_in = ST_DONE;
               step_in  = '0;
               if (res.hit && res.is_open) begin
                  if (res.owner_known) begin
                     uid_in   = res.uid;
                     found_in = 1'b1;
                  end else if (res.parent_known && hop_ff < HOP_W'(MAX_HOPS - 1)) begin
                     cur_in   = res.parent;
                     hop_in   = hop_ff + 1'b1;
                     state_in = ST_SCAN;
                  end
               end
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_DONE: begin
            out_v_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         out_v_ff <= 1'b0;
         step_ff  <= '0;
         hop_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         out_v_ff <= out_v_in;
         step_ff  <= step_in;
         hop_ff   <= hop_in;
      end
      qid_ff   <= qid_in;
      cur_ff   <= cur_in;
      qtime_ff <= qtime_in;
      uid_ff   <= uid_in;
      found_ff <= found_in;
      full_ff  <= full_in;
   end

   assign req_tready = state_ff == ST_IDLE && !out_v_ff;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {7'd0, full_ff, found_ff, uid_ff, qid_ff};

   // fill count never passes the depth
   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("fill count beyond depth");
   // no new transfer while a result waits
   assert property (@(posedge clock) disable iff (reset) out_v_ff |-> !req_tready)
      else $error("input taken while result pending");
   // hop count stays below the limit
   assert property (@(posedge clock) disable iff (reset) hop_ff < HOP_W'(MAX_HOPS))
      else $error("hop limit exceeded");
   // a result never reports both found and full
   assert property (@(posedge clock) disable iff (reset) rsp_tvalid |-> !(found_ff && full_ff))
      else $error("found and full together");
endmodule

// ----- tb/timed_owner_lookup_table_unit_test.sv -----
// Self-checking testbench for the timed owner lookup table unit.

class owner_scoreboard;
   localparam int DEPTH = 256;
   localparam int HOPS  = 10;

   logic [30:0] tab_pid    [DEPTH];
   logic [63:0] tab_stamp  [DEPTH];
   logic        tab_open   [DEPTH];
   logic        tab_pknown [DEPTH];
   logic [30:0] tab_parent [DEPTH];
   logic        tab_oknown [DEPTH];
   logic [31:0] tab_uid    [DEPTH];
   int          fill;
   logic [64:0] pending_rsp[$];
   int          errors;

   function new();
      fill = 0;
      errors = 0;
   endfunction

   // latest entry for id at or before t; earlier entry wins on ties
   function int latest_row(logic [30:0] id, logic [63:0] t);
      int best;
      best = -1;
      for (int i = 0; i < fill; i++) begin
         if (tab_pid[i] == id && tab_stamp[i] <= t) begin
            if (best < 0 || tab_stamp[i] > tab_stamp[best]) best = i;
         end
      end
      return best;
   endfunction

   // work out the answer to one accepted command and update the table
   function void note_command(logic cmd, logic [167:0] d);
      logic [30:0] id, cur;
      logic [63:0] t;
      logic [31:0] uid;
      logic        found, full;
      logic [64:0] item;
      int          e;
      id = d[30:0];
      t = d[94:31];
      uid = '0;
      found = 1'b0;
      full = 1'b0;
      if (cmd == tolt_pkg::CMD_APPEND) begin
         if (fill < DEPTH) begin
            tab_pid[fill]    = id;
            tab_stamp[fill]  = t;
            tab_open[fill]   = d[95];
            tab_parent[fill] = d[126:96];
            tab_pknown[fill] = d[127];
            tab_uid[fill]    = d[159:128];
            tab_oknown[fill] = d[160];
            fill++;
         end else begin
            full = 1'b1;
         end
      end else begin
         cur = id;
         for (int h = 0; h < HOPS; h++) begin
            e = latest_row(cur, t);
            if (e < 0 || !tab_open[e]) break;
            if (tab_oknown[e]) begin
               uid = tab_uid[e];
               found = 1'b1;
               break;
            end
            if (!tab_pknown[e]) break;
            cur = tab_parent[e];
         end
      end
      item = {full, found, uid, id};
      pending_rsp.insert(pending_rsp.size(), item);
   endfunction

   function void check_result(logic [71:0] d);
      logic [64:0] exp;
      if (pending_rsp.size() == 0) begin
         $display("%0t: unexpected result %h", $realtime, d);
         errors++;
         return;
      end
      exp = pending_rsp.pop_front();
      if (d[30:0] !== exp[30:0])
         $display("%0t: result_id exp %h got %h", $realtime, exp[30:0], d[30:0]);
      if (d[62:31] !== exp[62:31])
         $display("%0t: result_uid exp %h got %h", $realtime, exp[62:31], d[62:31]);
      if (d[63] !== exp[63])
         $display("%0t: uid_found exp %b got %b", $realtime, exp[63], d[63]);
      if (d[64] !== exp[64])
         $display("%0t: table_full exp %b got %b", $realtime, exp[64], d[64]);
      if (d[64:0] !== exp) errors++;
   endfunction
endclass

module timed_owner_lookup_table_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [167:0] req_tdata;
   logic         req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [71:0]  rsp_tdata;

   int           send_idle_pct;
   int           recv_idle_pct;
   logic [30:0]  id_pool[8];

   owner_scoreboard board;

   timed_owner_lookup_table_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // send one command and hold it until the transfer
   task automatic send_command(logic cmd, logic [30:0] id, logic [63:0] t,
                               logic op, logic [30:0] par, logic pk,
                               logic [31:0] uid, logic ok);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {7'd0, ok, uid, pk, par, op, t, id};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_command(cmd, {7'd0, ok, uid, pk, par, op, t, id});
   endtask

   task automatic send_random(logic cmd);
      logic [30:0] id, par;
      logic [63:0] t;
      id = ($urandom_range(9) == 0) ? 31'($urandom) : id_pool[$urandom_range(7)];
      par = ($urandom_range(9) == 0) ? 31'($urandom) : id_pool[$urandom_range(7)];
      t = ($urandom_range(19) == 0) ? {$urandom, $urandom} : 64'($urandom_range(200));
      if (cmd == tolt_pkg::CMD_SEARCH && $urandom_range(3) == 0) t = '1;
      send_command(cmd, id, t, $urandom_range(4) != 0, par, $urandom_range(1),
                   $urandom, $urandom_range(2) == 0);
   endtask

   // receiver with random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      #40ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      board = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = tolt_pkg::CMD_APPEND;
      send_idle_pct = 31;
      recv_idle_pct = 83;
      id_pool[0] = '0;
      id_pool[1] = '1;
      for (int i = 2; i < 8; i++) id_pool[i] = 31'($urandom);
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty search, extremes, parent chain, ties, close event
      send_command(tolt_pkg::CMD_SEARCH, id_pool[0], '0, 0, '0, 0, '0, 0);
      send_command(tolt_pkg::CMD_APPEND, id_pool[1], '1, 1, '0, 0, '1, 1);
      send_command(tolt_pkg::CMD_SEARCH, id_pool[1], '1, 1, '1, 1, '1, 1);
      send_command(tolt_pkg::CMD_SEARCH, id_pool[1], 64'hFFFF_FFFF_FFFF_FFFE,
                   0, '0, 0, '0, 0);
      send_command(tolt_pkg::CMD_APPEND, id_pool[2], 64'd5, 1, id_pool[3], 1, 32'd9, 0);
      send_command(tolt_pkg::CMD_APPEND, id_pool[3], 64'd5, 1, '0, 0, 32'h1234, 1);
      send_command(tolt_pkg::CMD_APPEND, id_pool[3], 64'd5, 1, '0, 0, 32'h5678, 1);
      send_command(tolt_pkg::CMD_SEARCH, id_pool[2], 64'd5, 0, '0, 0, '0, 0);
      send_command(tolt_pkg::CMD_APPEND, id_pool[3], 64'd7, 0, '0, 0, '0, 0);
      send_command(tolt_pkg::CMD_SEARCH, id_pool[2], 64'd8, 0, '0, 0, '0, 0);
      send_command(tolt_pkg::CMD_SEARCH, id_pool[2], 64'd6, 0, '0, 0, '0, 0);
      send_command(tolt_pkg::CMD_APPEND, id_pool[4], 64'd1, 1, '0, 0, '0, 0);
      send_command(tolt_pkg::CMD_SEARCH, id_pool[4], 64'd1, 0, '0, 0, '0, 0);
      // self loop exhausts the hop limit
      send_command(tolt_pkg::CMD_APPEND, id_pool[5], 64'd0, 1, id_pool[5], 1, '0, 0);
      send_command(tolt_pkg::CMD_SEARCH, id_pool[5], 64'd3, 0, '0, 0, '0, 0);
      // chain of nine hops ending in a known uid
      for (int k = 0; k < 9; k++)
         send_command(tolt_pkg::CMD_APPEND, 31'(1000 + k), 64'd2, 1, 31'(1001 + k), 1,
                      '0, 0);
      send_command(tolt_pkg::CMD_APPEND, 31'd1009, 64'd2, 1, '0, 0, 32'hCAFE, 1);
      send_command(tolt_pkg::CMD_SEARCH, 31'd1000, 64'd2, 0, '0, 0, '0, 0);

      // random: three idling phases, appends and searches mixed
      for (int ph = 0; ph < 3; ph++) begin
         if (ph == 1) begin send_idle_pct = 83; recv_idle_pct = 31; end
         if (ph == 2) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
         for (int n = 0; n < 68; n++)
            send_random(($urandom_range(1) == 0) ? tolt_pkg::CMD_APPEND
                                                  : tolt_pkg::CMD_SEARCH);
      end
      send_random(tolt_pkg::CMD_SEARCH);
      req_tvalid <= 1'b0;

      while (board.pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
